/* sv/hem_pkg.sv */
// package for the html element matcher core
// holds character codes, result status codes and the result record type
// no dependencies
`default_nettype none

package hem_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;

    localparam int RES_BITS = 16;

    typedef enum logic [2:0] {
        ST_FOUND   = 3'd0,
        ST_BAD     = 3'd1,
        ST_UNTERM  = 3'd2,
        ST_NOCLOSE = 3'd3,
        ST_OVER    = 3'd4
    } t_status;

    typedef struct packed {
        t_status               status;
        logic [RES_BITS-1:0]   start;
        logic [RES_BITS-1:0]   length;
    } t_result;

endpackage

`default_nettype wire

/* sv/html_element_matcher_core.sv */
// html element matcher core: finds the close tag matching a leading opening tag
// one text byte per request, one result request per buffer; depends on hem_pkg
// a two-entry result stage registers each result and absorbs output stalls
// throughput: one byte per cycle while its skid entry is empty, set by the compare
// of the byte against one stored tag-name byte and the depth update
// reset: synchronous active-low i_rst_n clears scan state, depth to one, mode to zero
`default_nettype none

module html_element_matcher_core #(
    parameter int MAX_TAG_LEN = 12,
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_data,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [7:0]               i_text_byte,
    input  wire logic                     i_end_of_buffer,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [2:0]                    o_status,
    output logic [hem_pkg::RES_BITS-1:0]  o_start_offset,
    output logic [hem_pkg::RES_BITS-1:0]  o_span_length
);

    import hem_pkg::*;

    localparam int TW = $clog2(MAX_TAG_LEN + 1);
    localparam int MW = $clog2(MAX_TAG_LEN + 3);
    localparam int IW = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;
    localparam logic [OFFSET_BITS-1:0] MAX_OFF = {OFFSET_BITS{1'b1}};

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_NAME,
        PH_HEAD,
        PH_BODY
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic                   r_sent, n_sent;
    logic [TW-1:0]          r_tag_len, n_tag_len;
    logic [MW-1:0]          r_mi, n_mi;
    logic                   r_mc, n_mc;
    logic [OFFSET_BITS-1:0] r_depth, n_depth;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_cstart, n_cstart;
    logic                   r_outer_mode;
    logic [7:0]             r_tag_name [MAX_TAG_LEN];

    t_result                r_out, r_skid, res;
    logic                   r_out_valid, r_skid_valid;
    logic                   push;

    logic                   accept, pop;
    logic                   wr_name;
    logic [MW-1:0]          rd_sel;
    logic [7:0]             name_rd;

    assign accept     = i_in_valid && o_in_ready;
    assign pop        = r_out_valid && i_out_ready;
    assign o_in_ready = !r_skid_valid;

    assign rd_sel  = r_mc ? (r_mi - MW'(2)) : (r_mi - MW'(1));
    assign name_rd = r_tag_name[rd_sel[IW-1:0]];

    always_comb begin
        logic [7:0]             c;
        logic                   opener, closer;
        logic [OFFSET_BITS-1:0] close_start;
        c           = i_text_byte;
        opener      = 1'b0;
        closer      = 1'b0;
        close_start = '0;
        n_phase     = r_phase;
        n_sent      = r_sent;
        n_tag_len   = r_tag_len;
        n_mi        = r_mi;
        n_mc        = r_mc;
        n_depth     = r_depth;
        n_pos       = r_pos;
        n_cstart    = r_cstart;
        wr_name     = 1'b0;
        push        = 1'b0;
        res         = '{status: ST_FOUND, start: '0, length: '0};

        if (!r_sent) begin
            if (r_pos == MAX_OFF) begin
                push   = 1'b1;
                n_sent = 1'b1;
                res.status = ST_OVER;
            end else begin
                n_pos = r_pos + OFFSET_BITS'(1);
                case (r_phase)
                    PH_FIRST: begin
                        if (c != CH_LT) begin
                            push = 1'b1; n_sent = 1'b1; res.status = ST_BAD;
                        end else begin
                            n_phase = PH_NAME;
                        end
                    end
                    PH_NAME: begin
                        if (c inside {[8'h41:8'h5a], [8'h61:8'h7a]}) begin
                            if (r_tag_len >= TW'(MAX_TAG_LEN)) begin
                                push = 1'b1; n_sent = 1'b1; res.status = ST_BAD;
                            end else begin
                                wr_name   = 1'b1;
                                n_tag_len = r_tag_len + TW'(1);
                            end
                        end else if (r_tag_len == '0) begin
                            push = 1'b1; n_sent = 1'b1; res.status = ST_BAD;
                        end else if (c == CH_GT) begin
                            n_cstart = r_pos + OFFSET_BITS'(1);
                            n_phase  = PH_BODY;
                        end else if (c == CH_SPACE) begin
                            n_phase = PH_HEAD;
                        end else begin
                            push = 1'b1; n_sent = 1'b1; res.status = ST_BAD;
                        end
                    end
                    PH_HEAD: begin
                        if (c == CH_NUL) begin
                            push = 1'b1; n_sent = 1'b1; res.status = ST_UNTERM;
                        end else if (c == CH_GT) begin
                            n_cstart = r_pos + OFFSET_BITS'(1);
                            n_phase  = PH_BODY;
                        end
                    end
                    PH_BODY: begin
                        if (c == CH_NUL) begin
                            push = 1'b1; n_sent = 1'b1; res.status = ST_NOCLOSE;
                        end else begin
                            // opener / closer matcher
                            if (r_mi == '0) begin
                                n_mc = 1'b0;
                                n_mi = (c == CH_LT) ? MW'(1) : MW'(0);
                            end else if (!r_mc) begin
                                if (r_mi == MW'(1) && c == CH_SLASH) begin
                                    n_mc = 1'b1;
                                    n_mi = MW'(2);
                                end else if (r_mi <= MW'(r_tag_len)) begin
                                    if (c == name_rd) begin
                                        n_mi = r_mi + MW'(1);
                                    end else begin
                                        n_mc = 1'b0;
                                        n_mi = (c == CH_LT) ? MW'(1) : MW'(0);
                                    end
                                end else if (c == CH_GT || c == CH_SPACE) begin
                                    n_mi   = '0;
                                    opener = 1'b1;
                                end else begin
                                    n_mc = 1'b0;
                                    n_mi = (c == CH_LT) ? MW'(1) : MW'(0);
                                end
                            end else begin
                                if (r_mi <= MW'(r_tag_len) + MW'(1)) begin
                                    if (c == name_rd) begin
                                        n_mi = r_mi + MW'(1);
                                    end else begin
                                        n_mc = 1'b0;
                                        n_mi = (c == CH_LT) ? MW'(1) : MW'(0);
                                    end
                                end else if (c == CH_GT) begin
                                    n_mi   = '0;
                                    n_mc   = 1'b0;
                                    closer = 1'b1;
                                end else begin
                                    n_mc = 1'b0;
                                    n_mi = (c == CH_LT) ? MW'(1) : MW'(0);
                                end
                            end

                            if (opener) begin
                                if (r_depth == MAX_OFF) begin
                                    push = 1'b1; n_sent = 1'b1; res.status = ST_OVER;
                                end else begin
                                    n_depth = r_depth + OFFSET_BITS'(1);
                                end
                            end else if (closer) begin
                                n_depth = r_depth - OFFSET_BITS'(1);
                                if (n_depth == '0) begin
                                    push        = 1'b1;
                                    n_sent      = 1'b1;
                                    res.status  = ST_FOUND;
                                    close_start = r_pos - OFFSET_BITS'(r_tag_len)
                                                  - OFFSET_BITS'(2);
                                    if (r_outer_mode) begin
                                        res.start  = '0;
                                        res.length = RES_BITS'(r_pos + OFFSET_BITS'(1));
                                    end else begin
                                        res.start  = RES_BITS'(r_cstart);
                                        res.length = RES_BITS'(close_start - r_cstart);
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_FIRST;
                    end
                endcase
            end
        end

        if (i_end_of_buffer) begin
            if (!n_sent) begin
                push = 1'b1;
                case (n_phase)
                    PH_FIRST, PH_NAME: res.status = ST_BAD;
                    PH_HEAD:           res.status = ST_UNTERM;
                    default:           res.status = ST_NOCLOSE;
                endcase
            end
            n_phase   = PH_FIRST;
            n_sent    = 1'b0;
            n_tag_len = '0;
            n_mi      = '0;
            n_mc      = 1'b0;
            n_depth   = OFFSET_BITS'(1);
            n_pos     = '0;
            n_cstart  = '0;
        end
    end

    // tag name store, no reset
    always_ff @(posedge i_clk) begin
        if (accept && wr_name) begin
            r_tag_name[r_tag_len[IW-1:0]] <= i_text_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_FIRST;
            r_sent       <= 1'b0;
            r_tag_len    <= '0;
            r_mi         <= '0;
            r_mc         <= 1'b0;
            r_depth      <= OFFSET_BITS'(1);
            r_pos        <= '0;
            r_cstart     <= '0;
            r_outer_mode <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_outer_mode <= i_cfg_data;
            end
            if (accept) begin
                r_phase   <= n_phase;
                r_sent    <= n_sent;
                r_tag_len <= n_tag_len;
                r_mi      <= n_mi;
                r_mc      <= n_mc;
                r_depth   <= n_depth;
                r_pos     <= n_pos;
                r_cstart  <= n_cstart;
            end
            // two-entry result stage
            if (accept && push) begin
                if (!r_out_valid || pop) begin
                    r_out       <= res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= res;
                    r_skid_valid <= 1'b1;
                end
            end else if (pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_start_offset = r_out.start;
    assign o_span_length  = r_out.length;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_tag_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_len <= TW'(MAX_TAG_LEN))
        else $error("tag length beyond store depth");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_FOUND) |-> (o_start_offset == '0 && o_span_length == '0))
        else $error("failed result carries non-zero span");

    a_depth_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY && !r_sent) |-> (r_depth != '0))
        else $error("nesting depth zero while scanning content");

endmodule

`default_nettype wire

/* test/tb_html_element_matcher_core.sv */
// testbench for html_element_matcher_core: streams text buffers and checks each result request
// against a built-in prediction of the close tag search; depends on hem_pkg and the core
// directed buffers first, then random well-formed and broken buffers under varying idling
`timescale 1ns / 1ps

module tb_html_element_matcher_core;
    import hem_pkg::*;

    typedef logic [7:0] t_byte;

    class element_span_model;
        typedef enum logic [1:0] {SCAN_FIRST, SCAN_NAME, SCAN_HEAD, SCAN_BODY} t_scan;
        typedef enum logic [1:0] {HIT_NONE, HIT_OPEN, HIT_CLOSE} t_hit;
        localparam int NAME_MAX = 12;
        localparam logic [15:0] OFFSET_TOP = 16'hFFFF;

        bit outer;
        t_scan scan;
        t_byte name_chars[NAME_MAX];
        int name_len;
        int match_at;
        bit match_close;
        bit decided;
        logic [15:0] depth;
        logic [15:0] offset;
        logic [15:0] body_start;
        t_result pending_spans[$];
        int mismatches;

        function new();
            outer = 1'b0;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            scan = SCAN_FIRST;
            name_len = 0;
            match_at = 0;
            match_close = 1'b0;
            decided = 1'b0;
            depth = 16'd1;
            offset = 16'd0;
            body_start = 16'd0;
        endfunction

        function void emit(t_status st, logic [15:0] span_start, logic [15:0] span_len);
            t_result r;
            r.status = st;
            r.start = span_start;
            r.length = span_len;
            pending_spans.push_back(r);
            decided = 1'b1;
        endfunction

        function t_byte name_at(int i);
            return (i >= 0 && i < name_len) ? name_chars[i] : CH_NUL;
        endfunction

        function void restart(t_byte c);
            match_close = 1'b0;
            match_at = (c == CH_LT) ? 1 : 0;
        endfunction

        function t_hit match_char(t_byte c);
            int i;
            i = match_at;
            if (i == 0) begin
                restart(c);
                return HIT_NONE;
            end
            if (!match_close) begin
                if (i == 1 && c == CH_SLASH) begin
                    match_close = 1'b1;
                    match_at = 2;
                    return HIT_NONE;
                end
                if (i <= name_len) begin
                    if (c == name_at(i - 1)) match_at = i + 1;
                    else restart(c);
                    return HIT_NONE;
                end
                if (c == CH_GT || c == CH_SPACE) begin
                    match_at = 0;
                    return HIT_OPEN;
                end
                restart(c);
                return HIT_NONE;
            end
            if (i <= name_len + 1) begin
                if (c == name_at(i - 2)) match_at = i + 1;
                else restart(c);
                return HIT_NONE;
            end
            if (c == CH_GT) begin
                match_at = 0;
                match_close = 1'b0;
                return HIT_CLOSE;
            end
            restart(c);
            return HIT_NONE;
        endfunction

        function void consume(t_byte c);
            logic [15:0] here;
            t_hit hit;
            here = offset;
            if (here == OFFSET_TOP) begin
                emit(ST_OVER, 16'd0, 16'd0);
                return;
            end
            offset = here + 16'd1;
            case (scan)
                SCAN_FIRST: begin
                    if (c != CH_LT) emit(ST_BAD, 16'd0, 16'd0);
                    else scan = SCAN_NAME;
                end
                SCAN_NAME: begin
                    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) begin
                        if (name_len >= NAME_MAX) begin
                            emit(ST_BAD, 16'd0, 16'd0);
                        end else begin
                            name_chars[name_len] = c;
                            name_len++;
                        end
                    end else if (name_len == 0) begin
                        emit(ST_BAD, 16'd0, 16'd0);
                    end else if (c == CH_GT) begin
                        body_start = here + 16'd1;
                        scan = SCAN_BODY;
                    end else if (c == CH_SPACE) begin
                        scan = SCAN_HEAD;
                    end else begin
                        emit(ST_BAD, 16'd0, 16'd0);
                    end
                end
                SCAN_HEAD: begin
                    if (c == CH_NUL) begin
                        emit(ST_UNTERM, 16'd0, 16'd0);
                    end else if (c == CH_GT) begin
                        body_start = here + 16'd1;
                        scan = SCAN_BODY;
                    end
                end
                default: begin
                    if (c == CH_NUL) begin
                        emit(ST_NOCLOSE, 16'd0, 16'd0);
                        return;
                    end
                    hit = match_char(c);
                    if (hit == HIT_OPEN) begin
                        if (depth == OFFSET_TOP) emit(ST_OVER, 16'd0, 16'd0);
                        else depth = depth + 16'd1;
                    end else if (hit == HIT_CLOSE) begin
                        depth = depth - 16'd1;
                        if (depth == 16'd0) begin
                            if (outer) emit(ST_FOUND, 16'd0, here + 16'd1);
                            else emit(ST_FOUND, body_start,
                                      here - 16'(name_len + 2) - body_start);
                        end
                    end
                end
            endcase
        endfunction

        // returns whether the byte still counted towards a decision
        function bit take_byte(t_byte c, bit last);
            bit live;
            live = !decided;
            if (!decided) consume(c);
            if (last) begin
                if (!decided) begin
                    if (scan == SCAN_FIRST || scan == SCAN_NAME) emit(ST_BAD, 16'd0, 16'd0);
                    else if (scan == SCAN_HEAD) emit(ST_UNTERM, 16'd0, 16'd0);
                    else emit(ST_NOCLOSE, 16'd0, 16'd0);
                end
                clear();
            end
            return live;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_span(logic [2:0] st, logic [15:0] span_start, logic [15:0] span_len);
            t_result want;
            if (pending_spans.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d start %0d length %0d",
                                          st, span_start, span_len));
                return;
            end
            want = pending_spans.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status got %0d want %0d", st, want.status));
            if (span_start !== want.start)
                report_mismatch($sformatf("start got %0d want %0d", span_start, want.start));
            if (span_len !== want.length)
                report_mismatch($sformatf("length got %0d want %0d", span_len, want.length));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_byte i_text_byte = 8'd0;
    logic i_end_of_buffer = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [2:0] o_status;
    logic [RES_BITS-1:0] o_start_offset;
    logic [RES_BITS-1:0] o_span_length;

    element_span_model sb;
    t_byte text_q[$];
    t_byte name_q[$];
    int send_idle = 0;
    int recv_stall = 0;
    int live_bytes = 0;

    html_element_matcher_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_end_of_buffer(i_end_of_buffer),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_start_offset (o_start_offset),
        .o_span_length  (o_span_length)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_span(o_status, o_start_offset, o_span_length);
        i_out_ready <= ($urandom_range(99) >= recv_stall);
    end

    function automatic t_byte random_letter();
        return $urandom_range(1) ? "A" + 8'($urandom_range(25)) : "a" + 8'($urandom_range(25));
    endfunction

    task automatic send_byte(t_byte b, bit last);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_text_byte <= b;
        i_end_of_buffer <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.take_byte(b, last)) live_bytes++;
    endtask

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
    endtask

    task automatic add_name();
        foreach (name_q[k]) text_q.push_back(name_q[k]);
    endtask

    task automatic send_text();
        foreach (text_q[k]) send_byte(text_q[k], k == text_q.size() - 1);
        text_q.delete();
    endtask

    task automatic send_line(string s);
        add_text(s);
        send_text();
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_spans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(bit m);
        i_cfg_we <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.outer = m;
    endtask

    task automatic run_directed();
        send_line("<div>hello</div>");
        send_line("<a><a>x</a></a>");
        send_line("<p class=x>t</p>");
        send_line("<b x><b y>z</b></b>");
        send_line("x<a>");
        send_line("y");
        send_line("<>");
        send_line("<abcdefghijklm>");
        send_line("<abcdefghijkl>q</abcdefghijkl>");
        send_line("<a#>");
        send_line("<ab");
        send_line("<");
        send_line("<a x");
        send_line("<a>xx");
        send_line("<a><<a></a></a>");
        send_line("<a></b></a>");
        send_line("<a>x</a>trailing");
        send_line("<Em>.<E</Em>");
        add_text("<a");
        text_q.push_back(CH_NUL);
        add_text(">");
        send_text();
        add_text("<a b");
        text_q.push_back(CH_NUL);
        add_text(">");
        send_text();
        add_text("<a>x");
        text_q.push_back(CH_NUL);
        add_text("</a>");
        send_text();
        add_text("<Z>");
        text_q.push_back(8'hFF);
        add_text("</Z>");
        send_text();
    endtask

    task automatic build_random_buffer();
        int depth;
        int steps;
        int cut;
        int part;
        text_q.delete();
        name_q.delete();
        repeat (($urandom_range(9) == 0) ? $urandom_range(12, 14) : $urandom_range(1, 4))
            name_q.push_back(random_letter());
        if ($urandom_range(11) == 0) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
            return;
        end
        text_q.push_back(CH_LT);
        add_name();
        if ($urandom_range(3) == 0) begin
            text_q.push_back(CH_SPACE);
            repeat ($urandom_range(3)) text_q.push_back(8'($urandom_range(1, 255)));
        end
        text_q.push_back(CH_GT);
        depth = 1;
        steps = $urandom_range(6);
        while (depth > 0) begin
            case ((steps > 0) ? $urandom_range(4) : 4)
                0: begin
                    text_q.push_back(CH_LT);
                    add_name();
                    text_q.push_back($urandom_range(1) ? CH_GT : CH_SPACE);
                    depth++;
                end
                1: begin
                    // opener or closer that stops short of the full name
                    text_q.push_back(CH_LT);
                    if ($urandom_range(1)) text_q.push_back(CH_SLASH);
                    part = $urandom_range(name_q.size() - 1);
                    for (int k = 0; k < part; k++) text_q.push_back(name_q[k]);
                end
                2, 3: begin
                    repeat ($urandom_range(1, 3))
                        text_q.push_back($urandom_range(1) ? random_letter()
                                                           : 8'($urandom_range(1, 255)));
                end
                default: begin
                    text_q.push_back(CH_LT);
                    text_q.push_back(CH_SLASH);
                    add_name();
                    text_q.push_back(CH_GT);
                    depth--;
                end
            endcase
            if (steps > 0) steps--;
        end
        case ($urandom_range(11))
            0: begin
                cut = $urandom_range(1, text_q.size());
                while (text_q.size() > cut) void'(text_q.pop_back());
            end
            1: text_q[$urandom_range(text_q.size() - 1)] = CH_NUL;
            2: text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom);
            3, 4: repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic run_random(int byte_goal, int buffer_goal);
        int buffers;
        int first_live;
        buffers = 0;
        first_live = live_bytes;
        while (live_bytes - first_live < byte_goal || buffers < buffer_goal) begin
            build_random_buffer();
            send_text();
            buffers++;
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain();
        write_mode(1'b1);
        run_directed();
        drain();
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin
                    send_idle = 0;
                    recv_stall = 0;
                end
                1: begin
                    send_idle = 46;
                    recv_stall = 0;
                end
                2: begin
                    send_idle = 0;
                    recv_stall = 46;
                end
                default: begin
                    send_idle = 36;
                    recv_stall = 36;
                end
            endcase
            write_mode(1'((p % 2) ^ (p / 4)));
            run_random(30, 2);
            drain();
        end
        if (sb.mismatches == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* html_element_matcher_core.f */
sv/hem_pkg.sv
sv/html_element_matcher_core.sv
test/tb_html_element_matcher_core.sv
